// File: src/gbts_pkg.sv
// Gap-buffer text store: shared constants, command codes and the
// control/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gbts_pkg;

	localparam int CAPACITY = 256;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = ADDR_W + 1;

	localparam logic [2:0] KIND_INSERT   = 3'd0;
	localparam logic [2:0] KIND_DELETE   = 3'd1;
	localparam logic [2:0] KIND_FORWARD  = 3'd2;
	localparam logic [2:0] KIND_BACKWARD = 3'd3;
	localparam logic [2:0] KIND_TO_START = 3'd4;
	localparam logic [2:0] KIND_TO_END   = 3'd5;
	localparam logic [2:0] KIND_READ     = 3'd6;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_BOUNDARY = 2'd2;
	localparam logic [1:0] ST_RANGE    = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic       latch;       // capture the incoming item
		logic       ins;         // write char at cursor, bump cursor and count
		logic       del;         // drop the char after the cursor
		logic       rd_fwd;      // read first char after the gap
		logic       rd_back;     // read last char before the gap
		logic       rd_idx;      // read at logical index
		logic       wr_fwd;      // finish a forward step
		logic       wr_back;     // finish a backward step
		logic       set_status;
		logic [1:0] status_code;
		logic       load_out;    // load the result register
	} gbts_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] kind;
		logic       full;
		logic       can_fwd;
		logic       can_back;
		logic       idx_ok;
	} gbts_flags_t;

endpackage
`default_nettype wire

// File: src/gbts_ctrl.sv
// Gap-buffer text store controller: sequences each item and the cursor walks.
// Depends on gbts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gbts_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire                 out_ready,
	input  gbts_pkg::gbts_flags_t flags,
	output gbts_pkg::gbts_cmd_t   cmd
);

	localparam logic [1:0] S_IDLE    = 2'd0;
	localparam logic [1:0] S_EXEC    = 2'd1;
	localparam logic [1:0] S_STEP_WR = 2'd2;
	localparam logic [1:0] S_FIN     = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       is_walk;
	logic       is_fwd;
	logic       can_load;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign is_walk   = (flags.kind inside {gbts_pkg::KIND_TO_START, gbts_pkg::KIND_TO_END});
	assign is_fwd    = (flags.kind inside {gbts_pkg::KIND_FORWARD, gbts_pkg::KIND_TO_END});
	assign can_load  = !out_valid_q || out_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_FIN;
				case (flags.kind)
					gbts_pkg::KIND_INSERT: begin
						if (flags.full) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = gbts_pkg::ST_FULL;
						end else begin
							cmd.ins = 1'b1;
						end
					end
					gbts_pkg::KIND_DELETE: begin
						if (flags.can_fwd) begin
							cmd.del = 1'b1;
						end else begin
							cmd.set_status  = 1'b1;
							cmd.status_code = gbts_pkg::ST_BOUNDARY;
						end
					end
					gbts_pkg::KIND_FORWARD, gbts_pkg::KIND_BACKWARD,
					gbts_pkg::KIND_TO_START, gbts_pkg::KIND_TO_END: begin
						if (is_fwd ? flags.can_fwd : flags.can_back) begin
							cmd.rd_fwd  = is_fwd;
							cmd.rd_back = !is_fwd;
							state_d     = S_STEP_WR;
						end else if (!is_walk) begin
							// single step at the boundary; a walk already there is fine
							cmd.set_status  = 1'b1;
							cmd.status_code = gbts_pkg::ST_BOUNDARY;
						end
					end
					gbts_pkg::KIND_READ: begin
						if (flags.idx_ok) begin
							cmd.rd_idx = 1'b1;
						end else begin
							cmd.set_status  = 1'b1;
							cmd.status_code = gbts_pkg::ST_RANGE;
						end
					end
					default: begin
						cmd.set_status  = 1'b1;
						cmd.status_code = gbts_pkg::ST_BOUNDARY;
					end
				endcase
			end
			S_STEP_WR: begin
				cmd.wr_fwd  = is_fwd;
				cmd.wr_back = !is_fwd;
				state_d     = is_walk ? S_EXEC : S_FIN;
			end
			S_FIN: begin
				if (can_load) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/gbts_datapath.sv
// Gap-buffer text store datapath: character memory, cursor/tail/count
// registers, item capture and the result register. Depends on gbts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gbts_datapath (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  [2:0]                   kind,
	input  wire  [7:0]                   char_in,
	input  wire  [7:0]                   read_index,
	input  gbts_pkg::gbts_cmd_t          cmd,
	output gbts_pkg::gbts_flags_t        flags,
	output logic [7:0]                   char_out,
	output logic [gbts_pkg::CNT_W-1:0]   cursor_pos,
	output logic [gbts_pkg::CNT_W-1:0]   text_length,
	output logic [1:0]                   status
);

	logic [7:0] mem [gbts_pkg::CAPACITY];

	logic [2:0]                 kind_q;
	logic [7:0]                 char_q;
	logic [7:0]                 idx_q;
	logic [gbts_pkg::CNT_W-1:0] cursor_q;
	logic [gbts_pkg::CNT_W-1:0] tail_q;    // first slot after the gap
	logic [gbts_pkg::CNT_W-1:0] count_q;
	logic [1:0]                 status_q;
	logic [7:0]                 rdata_q;

	logic [gbts_pkg::CNT_W-1:0]  idx_ext;
	logic [gbts_pkg::CNT_W-1:0]  cursor_dec;
	logic [gbts_pkg::CNT_W-1:0]  tail_dec;
	logic [gbts_pkg::CNT_W-1:0]  idx_far;
	logic [gbts_pkg::ADDR_W-1:0] rd_addr;
	logic [gbts_pkg::ADDR_W-1:0] wr_addr;
	logic [7:0]                  wr_data;
	logic                        rd_en;
	logic                        wr_en;

	assign idx_ext    = {1'b0, idx_q};
	assign cursor_dec = cursor_q - 1'b1;
	assign tail_dec   = tail_q - 1'b1;
	// index past the cursor: skip the gap, idx + CAPACITY - count
	assign idx_far    = idx_ext - count_q;

	assign flags.kind     = kind_q;
	assign flags.full     = (count_q == gbts_pkg::CNT_W'(gbts_pkg::CAPACITY));
	assign flags.can_fwd  = (cursor_q < count_q);
	assign flags.can_back = (cursor_q != '0);
	assign flags.idx_ok   = (idx_ext < count_q);

	always_comb begin
		rd_en   = cmd.rd_fwd | cmd.rd_back | cmd.rd_idx;
		rd_addr = tail_q[gbts_pkg::ADDR_W-1:0];
		if (cmd.rd_back) begin
			rd_addr = cursor_dec[gbts_pkg::ADDR_W-1:0];
		end else if (cmd.rd_idx) begin
			rd_addr = (idx_ext < cursor_q) ? idx_ext[gbts_pkg::ADDR_W-1:0]
			                               : idx_far[gbts_pkg::ADDR_W-1:0];
		end
		wr_en   = cmd.ins | cmd.wr_fwd | cmd.wr_back;
		wr_addr = cmd.wr_back ? tail_dec[gbts_pkg::ADDR_W-1:0]
		                      : cursor_q[gbts_pkg::ADDR_W-1:0];
		wr_data = cmd.ins ? char_q : rdata_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// item capture and result register: payload only
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= kind;
			char_q <= char_in;
			idx_q  <= read_index;
		end
		if (cmd.load_out) begin
			char_out    <= (kind_q == gbts_pkg::KIND_READ && status_q == gbts_pkg::ST_OK)
			               ? rdata_q : 8'd0;
			cursor_pos  <= cursor_q;
			text_length <= count_q;
			status      <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			tail_q   <= gbts_pkg::CNT_W'(gbts_pkg::CAPACITY);
			count_q  <= '0;
			status_q <= gbts_pkg::ST_OK;
		end else begin
			if (cmd.latch) begin
				status_q <= gbts_pkg::ST_OK;
			end else if (cmd.set_status) begin
				status_q <= cmd.status_code;
			end
			if (cmd.ins) begin
				cursor_q <= cursor_q + 1'b1;
				count_q  <= count_q + 1'b1;
			end
			if (cmd.del) begin
				tail_q  <= tail_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
			if (cmd.wr_fwd) begin
				tail_q   <= tail_q + 1'b1;
				cursor_q <= cursor_q + 1'b1;
			end
			if (cmd.wr_back) begin
				tail_q   <= tail_dec;
				cursor_q <= cursor_dec;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/gap_buffer_text_store_top.sv
// Gap-buffer text store, top level: controller plus datapath.
// Depends on gbts_pkg, gbts_ctrl, gbts_datapath.
//
// Usage
//   Input channel (in_valid/in_ready) carries one command item: kind,
//   char_in (insert only) and read_index (read only). Output channel
//   (out_valid/out_ready) returns exactly one result item per command:
//   char_out, cursor_pos, text_length and status.
// Timing
//   One item is worked on at a time. Insert, delete, read, failed moves and
//   the unused code go through the execute and finish states to the result. A
//   single forward or backward step does one memory read, then one write.
//   A move to start or end repeats a read and a write per byte copied across
//   the gap (up to CAPACITY bytes).
//   in_ready returns the cycle after the result is loaded; no new item is
//   taken before then.
// Reset
//   arst_n clears cursor, length and gap; the character memory is not
//   cleared and is only ever read where text has been written.
// Back-pressure
//   If out_ready is low a finished item waits in the controller, in_ready
//   stays low and the output register holds; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module gap_buffer_text_store_top (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire  [2:0]                        kind,
	input  wire  [7:0]                        char_in,
	input  wire  [7:0]                        read_index,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [7:0]                        char_out,
	output logic [gbts_pkg::CNT_W-1:0]        cursor_pos,
	output logic [gbts_pkg::CNT_W-1:0]        text_length,
	output logic [1:0]                        status
);

	gbts_pkg::gbts_cmd_t   cmd;
	gbts_pkg::gbts_flags_t flags;

	// sequencing: item capture, step loop for the walks, result hand-off
	gbts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.flags     (flags),
		.cmd       (cmd)
	);

	// storage, pointers and the result register
	gbts_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.kind        (kind),
		.char_in     (char_in),
		.read_index  (read_index),
		.cmd         (cmd),
		.flags       (flags),
		.char_out    (char_out),
		.cursor_pos  (cursor_pos),
		.text_length (text_length),
		.status      (status)
	);

endmodule
`default_nettype wire
